/* hdl/pst_pkg.sv */
// shared types and constants for the priority task scheduler
// no dependencies
package pst_pkg;

  localparam int TaskSlots = 16;
  localparam int IdxW      = $clog2(TaskSlots);
  localparam int CntW      = IdxW + 1;

  localparam logic [15:0] SliceReloadRst = 16'd10;
  localparam logic [31:0] MinStackRst    = 32'd1024;

  localparam logic CfgSliceReload = 1'b0;
  localparam logic CfgMinStack    = 1'b1;

  typedef enum logic [2:0] {
    TS_UNUSED   = 3'd0,
    TS_READY    = 3'd1,
    TS_RUNNING  = 3'd2,
    TS_SLEEPING = 3'd3,
    TS_FINISHED = 3'd4
  } tstat_e;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_START  = 3'd1,
    OP_YIELD  = 3'd2,
    OP_TICK   = 3'd3,
    OP_SLEEP  = 3'd4,
    OP_FINISH = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RS_OK    = 2'd0,
    RS_FULL  = 2'd1,
    RS_STACK = 2'd2,
    RS_NORUN = 2'd3
  } rstat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE,
    S_SLICE_RD,
    S_SLICE_CHK,
    S_PICK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_clr;
    logic wake_step;
    logic slice_rd;
    logic slice_upd;
    logic pick_step;
    logic pick_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       cur_run;
    logic       scan_done;
    logic       expire;
    logic       out_busy;
  } sts_t;

endpackage

/* hdl/pst_ram.sv */
// generic single write port ram with registered read
// no dependencies
module pst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pst_ctrl.sv */
// scheduler sequencer: walks each operation through exec, scans and result
// depends on pst_pkg
module pst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pst_pkg::sts_t sts_i,
  output pst_pkg::cmd_t cmd_o
);
  import pst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec     = 1'b1;
        cmd_o.scan_clr = 1'b1;
        case (sts_i.op)
          OP_YIELD: state_d = S_PICK;
          OP_TICK:  state_d = S_WAKE;
          OP_SLEEP, OP_FINISH: state_d = sts_i.cur_run ? S_PICK : S_DONE;
          default:  state_d = S_DONE;
        endcase
      end
      S_WAKE: begin
        cmd_o.wake_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_SLICE_RD;
        end
      end
      S_SLICE_RD: begin
        cmd_o.slice_rd = 1'b1;
        state_d        = S_SLICE_CHK;
      end
      S_SLICE_CHK: begin
        cmd_o.scan_clr = 1'b1;
        if (!sts_i.cur_run) begin
          state_d = S_DONE;
        end else begin
          cmd_o.slice_upd = 1'b1;
          state_d         = sts_i.expire ? S_PICK : S_DONE;
        end
      end
      S_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.pick_commit = 1'b1;
          state_d           = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* hdl/pst_dpath.sv */
// scheduler datapath: task table, scan unit, time, config and result register
// depends on pst_pkg and pst_ram
module pst_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pst_pkg::cmd_t        cmd_i,
  output pst_pkg::sts_t        sts_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [2:0]           opcode_i,
  input  logic [7:0]           priority_req_i,
  input  logic [31:0]          stack_size_i,
  input  logic [15:0]          delta_ms_i,
  input  logic [31:0]          sleep_ms_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           status_o,
  output logic                 running_valid_o,
  output logic [3:0]           running_index_o,
  output logic [4:0]           running_id_o,
  output logic                 switched_o,
  output logic [4:0]           created_id_o,
  output logic [31:0]          tick_count_o,
  output logic [4:0]           task_total_o
);
  import pst_pkg::*;

  logic [15:0] slice_reload_q;
  logic [31:0] min_stack_q;

  logic [2:0]  op_q;
  logic [7:0]  prio_q;
  logic [31:0] stk_q;
  logic [15:0] delta_q;
  logic [31:0] sms_q;

  tstat_e      stat_q [TaskSlots];
  tstat_e      stat_d [TaskSlots];
  logic [CntW-1:0] used_q, used_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [31:0] time_q, time_d;

  logic [1:0]  res_q, res_d;
  logic [CntW-1:0] created_q, created_d;
  logic        was_valid_q, was_valid_d;
  logic [IdxW-1:0] was_idx_q, was_idx_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic        rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic        found_q, found_d;
  logic [IdxW-1:0] best_q, best_d;
  logic [7:0]  best_prio_q, best_prio_d;

  logic        out_valid_q;
  logic [1:0]  o_status_q;
  logic        o_rv_q, o_sw_q;
  logic [3:0]  o_idx_q;
  logic [4:0]  o_id_q, o_cid_q, o_tot_q;
  logic [31:0] o_time_q;

  logic            cur_run, now_valid, expire;
  logic [CntW:0]   pick_sum;
  logic [IdxW-1:0] scan_addr, raddr;
  logic [IdxW-1:0] used_idx;
  logic            prio_we, wake_we, slice_we;
  logic [IdxW-1:0] wake_waddr, slice_waddr;
  logic [31:0]     wake_wdata;
  logic [15:0]     slice_wdata;
  logic [7:0]      prio_rdata;
  logic [31:0]     wake_rdata;
  logic [15:0]     slice_rdata;

  assign cur_run   = (stat_q[cur_q] == TS_RUNNING);
  assign expire    = (slice_rdata <= delta_q);
  assign used_idx  = used_q[IdxW-1:0];
  assign pick_sum  = (CntW+1)'(cur_q) + (CntW+1)'(1) + (CntW+1)'(cnt_q);

  always_comb begin
    if (cmd_i.pick_step) begin
      if (pick_sum >= (CntW+1)'(TaskSlots)) begin
        scan_addr = IdxW'(pick_sum - (CntW+1)'(TaskSlots));
      end else begin
        scan_addr = IdxW'(pick_sum);
      end
    end else begin
      scan_addr = cnt_q[IdxW-1:0];
    end
    raddr = cmd_i.slice_rd ? cur_q : scan_addr;
  end

  always_comb begin
    stat_d      = stat_q;
    used_d      = used_q;
    cur_d       = cur_q;
    time_d      = time_q;
    res_d       = res_q;
    created_d   = created_q;
    was_valid_d = was_valid_q;
    was_idx_d   = was_idx_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    prio_we     = 1'b0;
    wake_we     = 1'b0;
    slice_we    = 1'b0;
    wake_waddr  = cur_q;
    wake_wdata  = time_q + sms_q;
    slice_waddr = cur_q;
    slice_wdata = slice_reload_q;

    if (cmd_i.exec) begin
      res_d       = RS_OK;
      created_d   = '0;
      was_valid_d = cur_run;
      was_idx_d   = cur_q;
      case (op_q)
        OP_CREATE: begin
          if (used_q == CntW'(TaskSlots)) begin
            res_d = RS_FULL;
          end else if (stk_q < min_stack_q) begin
            res_d = RS_STACK;
          end else begin
            prio_we          = 1'b1;
            slice_we         = 1'b1;
            slice_waddr      = used_idx;
            stat_d[used_idx] = TS_READY;
            used_d           = used_q + CntW'(1);
            created_d        = used_q + CntW'(1);
          end
        end
        OP_START: begin
          if (used_q == '0) begin
            res_d = RS_NORUN;
          end else begin
            if (cur_run) begin
              stat_d[cur_q] = TS_READY;
            end
            cur_d     = '0;
            stat_d[0] = TS_RUNNING;
          end
        end
        OP_YIELD: begin
          if (cur_run) begin
            stat_d[cur_q] = TS_READY;
          end
        end
        OP_TICK: time_d = time_q + 32'(delta_q);
        OP_SLEEP: begin
          if (!cur_run) begin
            res_d = RS_NORUN;
          end else begin
            stat_d[cur_q] = TS_SLEEPING;
            wake_we       = 1'b1;
          end
        end
        OP_FINISH: begin
          if (!cur_run) begin
            res_d = RS_NORUN;
          end else begin
            stat_d[cur_q] = TS_FINISHED;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.scan_clr) begin
      cnt_d   = '0;
      found_d = 1'b0;
    end

    if (cmd_i.wake_step || cmd_i.pick_step) begin
      if (cnt_q != CntW'(TaskSlots)) begin
        rd_vld_d = 1'b1;
        rd_idx_d = scan_addr;
        cnt_d    = cnt_q + CntW'(1);
      end
    end

    if (cmd_i.wake_step && rd_vld_q) begin
      if (stat_q[rd_idx_q] == TS_SLEEPING && wake_rdata <= time_q) begin
        stat_d[rd_idx_q] = TS_READY;
      end
    end

    if (cmd_i.pick_step && rd_vld_q) begin
      if (stat_q[rd_idx_q] == TS_READY && (!found_q || prio_rdata < best_prio_q)) begin
        found_d     = 1'b1;
        best_d      = rd_idx_q;
        best_prio_d = prio_rdata;
      end
    end

    if (cmd_i.pick_commit && found_q) begin
      cur_d          = best_q;
      stat_d[best_q] = TS_RUNNING;
    end

    if (cmd_i.slice_upd) begin
      slice_we = 1'b1;
      if (expire) begin
        stat_d[cur_q] = TS_READY;
      end else begin
        slice_wdata = slice_rdata - delta_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TaskSlots; i++) begin
        stat_q[i] <= TS_UNUSED;
      end
      used_q         <= '0;
      cur_q          <= '0;
      time_q         <= '0;
      slice_reload_q <= SliceReloadRst;
      min_stack_q    <= MinStackRst;
      cnt_q          <= '0;
      rd_vld_q       <= 1'b0;
      found_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      stat_q   <= stat_d;
      used_q   <= used_d;
      cur_q    <= cur_d;
      time_q   <= time_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSliceReload) begin
          slice_reload_q <= cfg_data_i[15:0];
        end else begin
          min_stack_q <= cfg_data_i;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign now_valid = cur_run;

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    created_q   <= created_d;
    was_valid_q <= was_valid_d;
    was_idx_q   <= was_idx_d;
    rd_idx_q    <= rd_idx_d;
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    if (cmd_i.accept) begin
      op_q    <= opcode_i;
      prio_q  <= priority_req_i;
      stk_q   <= stack_size_i;
      delta_q <= delta_ms_i;
      sms_q   <= sleep_ms_i;
    end
    if (cmd_i.out_load) begin
      o_status_q <= res_q;
      o_rv_q     <= now_valid;
      o_idx_q    <= 4'(cur_q);
      o_id_q     <= now_valid ? 5'(CntW'(cur_q) + CntW'(1)) : 5'd0;
      o_sw_q     <= (was_valid_q != now_valid) || (now_valid && was_idx_q != cur_q);
      o_cid_q    <= 5'(created_q);
      o_time_q   <= time_q;
      o_tot_q    <= 5'(used_q);
    end
  end

  pst_ram #(.Width(8), .Depth(TaskSlots)) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (used_idx),
    .wdata_i (prio_q),
    .raddr_i (raddr),
    .rdata_o (prio_rdata)
  );

  pst_ram #(.Width(32), .Depth(TaskSlots)) u_wake_ram (
    .clk_i   (clk_i),
    .we_i    (wake_we),
    .waddr_i (wake_waddr),
    .wdata_i (wake_wdata),
    .raddr_i (raddr),
    .rdata_o (wake_rdata)
  );

  pst_ram #(.Width(16), .Depth(TaskSlots)) u_slice_ram (
    .clk_i   (clk_i),
    .we_i    (slice_we),
    .waddr_i (slice_waddr),
    .wdata_i (slice_wdata),
    .raddr_i (raddr),
    .rdata_o (slice_rdata)
  );

  assign sts_o.op        = op_q;
  assign sts_o.cur_run   = cur_run;
  assign sts_o.scan_done = (cnt_q == CntW'(TaskSlots)) && !rd_vld_q;
  assign sts_o.expire    = expire;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign running_valid_o = o_rv_q;
  assign running_index_o = o_idx_q;
  assign running_id_o    = o_id_q;
  assign switched_o      = o_sw_q;
  assign created_id_o    = o_cid_q;
  assign tick_count_o    = o_time_q;
  assign task_total_o    = o_tot_q;

endmodule

/* hdl/priority_task_scheduler_unit.sv */
// Fixed-priority preemptive task scheduler over a 16-entry task table, one item at a time.
// Create, start, unknown operations and a sleep or finish with no running task go from accept
// through exec straight to the result. Yield, sleep and finish run one pass of the selection
// scan over all slots through the registered priority memory. Tick runs a wake scan over all
// wake times and a slice check, then the selection scan when the slice runs out.
// A new item is taken in the cycle after the previous result enters the output register,
// and a stalled result holds the sequencer. Configuration writes are registered.
// depends on pst_pkg, pst_ctrl, pst_dpath
module priority_task_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  priority_req_i,
  input  logic [31:0] stack_size_i,
  input  logic [15:0] delta_ms_i,
  input  logic [31:0] sleep_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        running_valid_o,
  output logic [3:0]  running_index_o,
  output logic [4:0]  running_id_o,
  output logic        switched_o,
  output logic [4:0]  created_id_o,
  output logic [31:0] tick_count_o,
  output logic [4:0]  task_total_o
);
  import pst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pst_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .priority_req_i  (priority_req_i),
    .stack_size_i    (stack_size_i),
    .delta_ms_i      (delta_ms_i),
    .sleep_ms_i      (sleep_ms_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .running_valid_o (running_valid_o),
    .running_index_o (running_index_o),
    .running_id_o    (running_id_o),
    .switched_o      (switched_o),
    .created_id_o    (created_id_o),
    .tick_count_o    (tick_count_o),
    .task_total_o    (task_total_o)
  );

endmodule

/* hdl/pst_checker.sv */
// port level checks for the scheduler, bound to the top level
// depends on pst_pkg
module pst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic        running_valid_o,
  input logic [3:0]  running_index_o,
  input logic [4:0]  running_id_o,
  input logic [4:0]  created_id_o,
  input logic [4:0]  task_total_o
);
  import pst_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_run_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (running_valid_o ? running_id_o == 5'(running_index_o) + 5'd1
                                     : running_id_o == 5'd0))
    else $error("running id mismatch");

  a_created_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && created_id_o != 5'd0 |-> status_o == RS_OK && created_id_o == task_total_o)
    else $error("bad created id");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == RS_FULL |-> task_total_o == 5'(TaskSlots))
    else $error("table full with free slots");

endmodule

bind priority_task_scheduler_unit pst_checker u_pst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .running_valid_o (running_valid_o),
  .running_index_o (running_index_o),
  .running_id_o    (running_id_o),
  .created_id_o    (created_id_o),
  .task_total_o    (task_total_o)
);

/* verif/tb_priority_task_scheduler_unit.sv */
// self-checking testbench for priority_task_scheduler_unit: directed and random items
// scored against an in-bench scheduler predictor; depends on pst_pkg and the dut rtl
`timescale 1ns / 1ps

module tb_priority_task_scheduler_unit;
  import pst_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  prio;
    logic [31:0] stk;
    logic [15:0] delta;
    logic [31:0] sms;
  } sched_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        run_vld;
    logic [3:0]  run_idx;
    logic [4:0]  run_id;
    logic        switched;
    logic [4:0]  created;
    logic [31:0] ticks;
    logic [4:0]  total;
  } sched_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic [31:0] stack_size_i = '0;
  logic [15:0] delta_ms_i = '0;
  logic [31:0] sleep_ms_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        running_valid_o;
  logic [3:0]  running_index_o;
  logic [4:0]  running_id_o;
  logic        switched_o;
  logic [4:0]  created_id_o;
  logic [31:0] tick_count_o;
  logic [4:0]  task_total_o;
  logic        in_acc_q = 1'b0;

  priority_task_scheduler_unit u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  tstat_e      tbl_stat [TaskSlots];
  logic [7:0]  tbl_prio [TaskSlots];
  logic [31:0] tbl_wake [TaskSlots];
  logic [15:0] tbl_slice [TaskSlots];
  int unsigned n_tasks, cur_idx;
  logic [31:0] sys_time;
  logic [15:0] slice_cfg;
  logic [31:0] min_stk_cfg;

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  int send_idle_pct, recv_stall_pct;
  int n_mismatch, n_results, n_sent;

  function automatic bit is_running();
    return cur_idx < n_tasks && tbl_stat[cur_idx] == TS_RUNNING;
  endfunction

  function automatic void dispatch_next();
    int unsigned best, idx;
    best = TaskSlots;
    for (int k = 1; k <= TaskSlots; k++) begin
      idx = (cur_idx + k) % TaskSlots;
      if (idx < n_tasks && tbl_stat[idx] == TS_READY)
        if (best == TaskSlots || tbl_prio[idx] < tbl_prio[best]) best = idx;
    end
    if (best < TaskSlots) begin
      cur_idx = best;
      tbl_stat[best] = TS_RUNNING;
    end
  endfunction

  function automatic void yield_cur();
    if (is_running()) tbl_stat[cur_idx] = TS_READY;
    dispatch_next();
  endfunction

  function automatic sched_rsp_t schedule_step(sched_req_t r);
    sched_rsp_t o;
    bit was_run, now_run;
    int unsigned was_idx;
    was_run = is_running();
    was_idx = cur_idx;
    o = '0;
    case (r.op)
      OP_CREATE: begin
        if (n_tasks >= TaskSlots) o.status = RS_FULL;
        else if (r.stk < min_stk_cfg) o.status = RS_STACK;
        else begin
          tbl_prio[n_tasks] = r.prio;
          tbl_stat[n_tasks] = TS_READY;
          tbl_slice[n_tasks] = slice_cfg;
          tbl_wake[n_tasks] = '0;
          n_tasks++;
          o.created = 5'(n_tasks);
        end
      end
      OP_START: begin
        if (n_tasks == 0) o.status = RS_NORUN;
        else begin
          if (is_running() && cur_idx != 0) tbl_stat[cur_idx] = TS_READY;
          cur_idx = 0;
          tbl_stat[0] = TS_RUNNING;
        end
      end
      OP_YIELD: yield_cur();
      OP_TICK: begin
        sys_time += r.delta;
        for (int i = 0; i < n_tasks; i++)
          if (tbl_stat[i] == TS_SLEEPING && tbl_wake[i] <= sys_time) begin
            tbl_stat[i] = TS_READY;
            tbl_wake[i] = '0;
          end
        if (is_running()) begin
          if (tbl_slice[cur_idx] <= r.delta) begin
            tbl_slice[cur_idx] = slice_cfg;
            yield_cur();
          end else tbl_slice[cur_idx] -= r.delta;
        end
      end
      OP_SLEEP, OP_FINISH: begin
        if (!is_running()) o.status = RS_NORUN;
        else begin
          if (r.op == OP_SLEEP) begin
            tbl_stat[cur_idx] = TS_SLEEPING;
            tbl_wake[cur_idx] = sys_time + r.sms;
          end else tbl_stat[cur_idx] = TS_FINISHED;
          dispatch_next();
        end
      end
      default: ;
    endcase
    now_run = is_running();
    o.run_vld = now_run;
    o.run_idx = cur_idx[3:0];
    o.run_id = now_run ? 5'(cur_idx + 1) : 5'd0;
    o.switched = (was_run != now_run) || (now_run && was_idx != cur_idx);
    o.ticks = sys_time;
    o.total = n_tasks[4:0];
    return o;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_acc_q) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sched_req_t r;
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          {opcode_i, priority_req_i, stack_size_i, delta_ms_i, sleep_ms_i} <= r;
        end else in_valid_i <= 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accept edge: predict; result edge: check
  always @(posedge clk_i) begin
    in_acc_q <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      sched_req_t r;
      r = {opcode_i, priority_req_i, stack_size_i, delta_ms_i, sleep_ms_i};
      expected_rsps.push_back(schedule_step(r));
      n_sent++;
    end
    if (out_valid_o && out_ready_i) begin
      sched_rsp_t got, exp_r;
      got = {status_o, running_valid_o, running_index_o, running_id_o, switched_o,
             created_id_o, tick_count_o, task_total_o};
      n_results++;
      if (expected_rsps.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (got !== exp_r) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch at result %0d: expected %h actual %h", n_results, exp_r, got);
        end
      end
    end
  end

  task automatic write_cfg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSliceReload) slice_cfg = val[15:0];
    else min_stk_cfg = val;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic sched_req_t rand_req(int unsigned wt_create);
    sched_req_t r;
    int unsigned sel;
    r.prio = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    r.stk = $urandom;
    if ($urandom_range(3) == 0) r.stk = min_stk_cfg + $urandom_range(2) - 1;
    r.delta = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(12));
    r.sms = ($urandom_range(7) == 0) ? $urandom : $urandom_range(40);
    sel = $urandom_range(99);
    if (sel < wt_create) r.op = OP_CREATE;
    else if (sel < wt_create + 5) r.op = OP_START;
    else if (sel < wt_create + 20) r.op = OP_YIELD;
    else if (sel < wt_create + 55) r.op = OP_TICK;
    else if (sel < wt_create + 70) r.op = OP_SLEEP;
    else if (sel < wt_create + 77) r.op = OP_FINISH;
    else if (sel < 98) r.op = OP_TICK;
    else r.op = 3'($urandom_range(7, 6));
    return r;
  endfunction

  task automatic push(logic [2:0] op, logic [7:0] p, logic [31:0] s, logic [15:0] d,
                      logic [31:0] m);
    pending_reqs.push_back({op, p, s, d, m});
  endtask

  initial begin
    int idle_sets[4][2] = '{'{0, 0}, '{77, 0}, '{0, 77}, '{12, 12}};
    for (int i = 0; i < TaskSlots; i++) tbl_stat[i] = TS_UNUSED;
    n_tasks = 0; cur_idx = 0; sys_time = '0;
    slice_cfg = SliceReloadRst; min_stk_cfg = MinStackRst;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_mismatch = 0; n_results = 0; n_sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed
    push(OP_START, 0, 0, 0, 0);
    push(OP_YIELD, 0, 0, 0, 0);
    push(OP_SLEEP, 0, 0, 0, 5);
    push(OP_FINISH, 0, 0, 0, 0);
    push(3'd6, 8'hff, '1, '1, '1);
    push(3'd7, 0, 0, 0, 0);
    push(OP_CREATE, 0, 32'd1023, 0, 0);
    push(OP_CREATE, 8'hff, '1, 0, 0);
    push(OP_CREATE, 8'h00, 32'd1024, 0, 0);
    push(OP_CREATE, 8'h00, 32'd5000, 0, 0);
    push(OP_START, 0, 0, 0, 0);
    push(OP_TICK, 0, 0, 16'd3, 0);
    push(OP_TICK, 0, 0, 16'hffff, 0);
    push(OP_SLEEP, 0, 0, 0, 32'hffff_ffff);
    push(OP_TICK, 0, 0, 16'd0, 0);
    push(OP_YIELD, 0, 0, 0, 0);
    push(OP_FINISH, 0, 0, 0, 0);
    push(OP_FINISH, 0, 0, 0, 0);
    push(OP_TICK, 0, 0, 16'd10, 0);
    for (int i = 0; i < 15; i++) push(OP_CREATE, 8'(i % 3), 32'h8000_0000, 0, 0);
    push(OP_START, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = idle_sets[ph % 4][0];
      recv_stall_pct = idle_sets[ph % 4][1];
      @(negedge clk_i);
      rst_ni <= rst_ni;
      case (ph % 4)
        0: begin write_cfg(CfgSliceReload, 32'd1); write_cfg(CfgMinStack, 32'd0); end
        1: begin write_cfg(CfgSliceReload, 32'hffff); write_cfg(CfgMinStack, '1); end
        2: begin write_cfg(CfgSliceReload, 32'd0); write_cfg(CfgMinStack, 32'd100); end
        default: begin
          write_cfg(CfgSliceReload, $urandom_range(1, 30));
          write_cfg(CfgMinStack, $urandom);
        end
      endcase
      for (int k = 0; k < 190; k++) pending_reqs.push_back(rand_req(n_tasks < 16 ? 20 : 3));
      drain();
    end

    $display("covered %0d items and %0d results over 8 config and idle phases",
             n_sent, n_results);
    $display("final task count %0d, system time %0d", n_tasks, sys_time);
    if (n_mismatch == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hdl/pst_pkg.sv
hdl/pst_ram.sv
hdl/pst_ctrl.sv
hdl/pst_dpath.sv
hdl/priority_task_scheduler_unit.sv
hdl/pst_checker.sv
verif/tb_priority_task_scheduler_unit.sv
